// ===== design/sow_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo overdrive waveshaper package
// Shared widths, codes and control types for the waveshaper datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sow_pkg;

   // Sample, gain and fixed-point widths.
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int FRAC_W   = 16;

   // Configuration port geometry.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int REG_SEL_BIT = 2;

   // Register reset values and shaping constants.
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
   localparam int CLIP_LEVEL  = 9830;
   localparam int SAT_POS     = 32767;
   localparam int SAT_NEG_MAG = 32768;

   // Division by three as a reciprocal multiply; exact for 16-bit operands.
   localparam int DIV3_RECIP = 43691;
   localparam int DIV3_SHIFT = 17;

   // Number of register stages from input to output.
   localparam int NUM_STAGES = 7;

   typedef enum logic [1:0] {
      MODE_NATURAL = 2'd0,
      MODE_CLIP    = 2'd1,
      MODE_EXP     = 2'd2,
      MODE_ASYM    = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      REG_GAIN = 1'b0,
      REG_MODE = 1'b1
   } reg_index_type;

   // Stage load strobes and the settings that both channels share.
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [GAIN_W-1:0]     gain;
      mode_type              mode;
   } sow_ctrl_type;

endpackage

`default_nettype wire

// ===== design/sow_if.sv =====
// ----------------------------------------------------------------------------
// Stereo overdrive waveshaper stream interfaces
// Valid/ready channels for sample pairs in and shaped pairs out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sow_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sow_pkg::SAMPLE_W-1:0] left_in;
   logic signed [sow_pkg::SAMPLE_W-1:0] right_in;
   logic                                end_of_buffer;

   modport source (output valid, output left_in, output right_in,
                   output end_of_buffer, input ready);
   modport sink   (input valid, input left_in, input right_in,
                   input end_of_buffer, output ready);
endinterface

interface sow_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sow_pkg::SAMPLE_W-1:0] left_out;
   logic signed [sow_pkg::SAMPLE_W-1:0] right_out;
   logic                                last_out;

   modport source (output valid, output left_out, output right_out,
                   output last_out, input ready);
   modport sink   (input valid, input left_out, input right_out,
                   input last_out, output ready);
endinterface

`default_nettype wire

// ===== design/sow_channel.sv =====
// ----------------------------------------------------------------------------
// Waveshaper channel datapath
// Seven-stage gain, shaping and exponential-table interpolation for one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sow_channel #(
   parameter int EXP_TABLE_ENTRIES  = 256,
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  wire logic                                clock,
   input  wire sow_pkg::sow_ctrl_type               ctrl,
   input  wire logic signed [sow_pkg::SAMPLE_W-1:0] sample_in,
   output logic signed [sow_pkg::SAMPLE_W-1:0]      sample_out
);

   localparam int SW     = sow_pkg::SAMPLE_W;
   localparam int FW     = sow_pkg::FRAC_W;
   localparam int P_W    = SW + sow_pkg::GAIN_W + 1;
   localparam int A_W    = P_W - 2;
   localparam int KA_W   = A_W + 2;
   localparam int NB     = $clog2(EXP_TABLE_ENTRIES + 1);
   localparam int PR_W   = KA_W + NB;
   localparam int POS_W  = PR_W - 1 - GAIN_FRACTION_BITS;
   localparam int IDXF_W = POS_W - FW;
   localparam int IDX_W  = $clog2(EXP_TABLE_ENTRIES);
   localparam int M_W    = A_W - GAIN_FRACTION_BITS;

   // Table entry i holds 1 - e^(-12*i/N) in Q0.16, built from a Taylor series
   // of e^(-t/16) followed by four squarings.
   function automatic logic [FW-1:0] rom_entry(input int i);
      logic [63:0]        w;
      logic [63:0]        term;
      logic [63:0]        e;
      logic signed [63:0] sum;
      w    = (64'(3 * i) << 32) / 64'(4 * EXP_TABLE_ENTRIES);
      sum  = 64'sh1_0000_0000;
      term = 64'h1_0000_0000;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * w) >> 32) / 64'(k);
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      e = $unsigned(sum);
      for (int r = 0; r < 4; r++) begin
         if (e < 64'h1_0000_0000) begin
            e = (e * e + 64'h8000_0000) >> 32;
         end else begin
            e = 64'h1_0000_0000;
         end
      end
      e = (e + 64'h8000) >> 16;
      if (e > 64'h1_0000) begin
         e = 64'h1_0000;
      end
      e = 64'h1_0000 - e;
      if (e > 64'hFFFF) begin
         e = 64'hFFFF;
      end
      return e[FW-1:0];
   endfunction

   // Each word holds an entry and the step to the next one.
   logic [2*FW-1:0] rom_word [EXP_TABLE_ENTRIES];

   for (genvar gi = 0; gi < EXP_TABLE_ENTRIES; gi++) begin : g_rom
      localparam logic [FW-1:0] LO = rom_entry(gi);
      localparam logic [FW-1:0] HI = rom_entry(gi + 1);
      assign rom_word[gi] = {LO, FW'(HI - LO)};
   end

   localparam logic [FW-1:0] ROM_END = rom_entry(EXP_TABLE_ENTRIES);

   // Stage registers.
   logic signed [P_W-1:0] p_ff;
   logic signed [P_W-1:0] p_in;
   logic [A_W-1:0]        a_ff;
   logic [A_W-1:0]        a_in;
   logic [KA_W-1:0]       ka_ff;
   logic [KA_W-1:0]       ka_in;
   logic [POS_W-1:0]      pos_ff;
   logic [POS_W-1:0]      pos_in;
   logic [FW-1:0]         base_ff;
   logic [FW-1:0]         base_in;
   logic [FW-1:0]         delta_ff;
   logic [FW-1:0]         delta_in;
   logic [FW-1:0]         frac_ff;
   logic [FW-1:0]         frac_in;
   logic [FW-1:0]         e_ff;
   logic [FW-1:0]         e_in;
   logic [SW-1:0]         out_ff;
   logic [SW-1:0]         out_in;
   logic [SW-1:0]         lin_ff [3:6];
   logic [SW-1:0]         lin_in;
   logic                  neg_ff [2:6];
   logic                  neg_in;

   logic [P_W-1:0]        p_abs;
   logic                  triple;
   logic [M_W-1:0]        m_val;
   logic [SW:0]           lin_mag;
   logic [SW:0]           lin_val;
   logic [PR_W-1:0]       pos_prod;
   logic [IDXF_W-1:0]     idx_full;
   logic [2*FW-1:0]       word;
   logic [2*FW-1:0]       interp_prod;
   logic [FW:0]           interp_sum;
   logic [2*FW-1:0]       div3_prod;
   logic [SW-1:0]         exp_mag;
   logic [SW-1:0]         exp_val;

   // Stage 1: gain multiply.
   assign p_in = $signed(sample_in) * $signed({1'b0, ctrl.gain});

   // Stage 2: magnitude and sign.
   assign neg_in = p_ff[P_W-1];
   assign p_abs  = neg_in ? -p_ff : p_ff;
   assign a_in   = p_abs[A_W-1:0];

   // Stage 3: curve steepness and the natural or clipped result.
   assign triple = (ctrl.mode == sow_pkg::MODE_ASYM) && !neg_ff[2];
   assign ka_in  = triple ? KA_W'(a_ff) + KA_W'({a_ff, 1'b0}) : KA_W'(a_ff);
   assign m_val  = a_ff[A_W-1:GAIN_FRACTION_BITS];

   always_comb begin
      if (ctrl.mode == sow_pkg::MODE_CLIP) begin
         lin_mag = (m_val > M_W'(sow_pkg::CLIP_LEVEL)) ?
                   (SW+1)'(sow_pkg::CLIP_LEVEL) : m_val[SW:0];
      end else if (neg_ff[2]) begin
         lin_mag = (m_val > M_W'(sow_pkg::SAT_NEG_MAG)) ?
                   (SW+1)'(sow_pkg::SAT_NEG_MAG) : m_val[SW:0];
      end else begin
         lin_mag = (m_val > M_W'(sow_pkg::SAT_POS)) ?
                   (SW+1)'(sow_pkg::SAT_POS) : m_val[SW:0];
      end
      lin_val = neg_ff[2] ? (~lin_mag + 1'b1) : lin_mag;
   end

   assign lin_in = lin_val[SW-1:0];

   // Stage 4: position in the table, Q16.
   assign pos_prod = PR_W'(ka_ff) * PR_W'(EXP_TABLE_ENTRIES);
   assign pos_in   = pos_prod[PR_W-1:GAIN_FRACTION_BITS+1];

   // Stage 5: table lookup; beyond the table the curve holds its last entry.
   assign idx_full = pos_ff[POS_W-1:FW];
   assign word     = rom_word[idx_full[IDX_W-1:0]];

   always_comb begin
      if (idx_full >= IDXF_W'(EXP_TABLE_ENTRIES)) begin
         base_in  = ROM_END;
         delta_in = '0;
      end else begin
         base_in  = word[2*FW-1:FW];
         delta_in = word[FW-1:0];
      end
   end

   assign frac_in = pos_ff[FW-1:0];

   // Stage 6: linear interpolation.
   assign interp_prod = (2*FW)'(delta_ff) * (2*FW)'(frac_ff);
   assign interp_sum  = {1'b0, base_ff} + {1'b0, interp_prod[2*FW-1:FW]};
   assign e_in        = interp_sum[FW-1:0];

   // Stage 7: output scaling, divide by three for the steep positive half.
   assign div3_prod = (2*FW)'(e_ff) * (2*FW)'(sow_pkg::DIV3_RECIP);

   always_comb begin
      if ((ctrl.mode == sow_pkg::MODE_ASYM) && !neg_ff[6]) begin
         exp_mag = SW'(div3_prod[2*FW-1:sow_pkg::DIV3_SHIFT+1]);
      end else begin
         exp_mag = {1'b0, e_ff[FW-1:1]};
      end
      exp_val = neg_ff[6] ? (~exp_mag + 1'b1) : exp_mag;
      case (ctrl.mode) inside
         sow_pkg::MODE_NATURAL, sow_pkg::MODE_CLIP: out_in = lin_ff[6];
         default:                                   out_in = exp_val;
      endcase
   end

   // Stage registers advance on their load strobes.
   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         p_ff <= p_in;
      end
      if (ctrl.load[1]) begin
         a_ff      <= a_in;
         neg_ff[2] <= neg_in;
      end
      if (ctrl.load[2]) begin
         ka_ff     <= ka_in;
         lin_ff[3] <= lin_in;
         neg_ff[3] <= neg_ff[2];
      end
      if (ctrl.load[3]) begin
         pos_ff    <= pos_in;
         lin_ff[4] <= lin_ff[3];
         neg_ff[4] <= neg_ff[3];
      end
      if (ctrl.load[4]) begin
         base_ff   <= base_in;
         delta_ff  <= delta_in;
         frac_ff   <= frac_in;
         lin_ff[5] <= lin_ff[4];
         neg_ff[5] <= neg_ff[4];
      end
      if (ctrl.load[5]) begin
         e_ff      <= e_in;
         lin_ff[6] <= lin_ff[5];
         neg_ff[6] <= neg_ff[5];
      end
      if (ctrl.load[6]) begin
         out_ff <= out_in;
      end
   end

   assign sample_out = $signed(out_ff);

endmodule

`default_nettype wire

// ===== design/stereo_overdrive_waveshaper.sv =====
// ----------------------------------------------------------------------------
// Stereo overdrive waveshaper
// Gain and soft-clip shaping of stereo sample pairs, with an APB-style
// register port for gain and mode.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the seven-stage datapath (gain multiply,
// position multiply, table lookup, interpolation and divide-by-three
// multiplies) is fully pipelined and stalls only when every stage is full
// and the output side is not ready.
// Reset clears all stage valid bits, sets gain to 256 (unity) and mode to
// natural. The exponential table is constant and needs no initialization.
`default_nettype none

module stereo_overdrive_waveshaper #(
   parameter int EXP_TABLE_ENTRIES  = 256,
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sow_req_if.sink                                 req_chan,
   sow_rsp_if.source                               rsp_chan,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [sow_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [sow_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [sow_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                    pready
);

   localparam int NS = sow_pkg::NUM_STAGES;

   logic [sow_pkg::GAIN_W-1:0] gain_ff;
   logic [sow_pkg::GAIN_W-1:0] gain_in;
   sow_pkg::mode_type          mode_ff;
   sow_pkg::mode_type          mode_in;
   logic                       csr_write;
   sow_pkg::reg_index_type     reg_sel;

   logic [NS-1:0]              v_ff;
   logic [NS-1:0]              v_in;
   logic [NS-1:0]              last_ff;
   logic [NS-1:0]              last_in;
   logic [NS-1:0]              ld;
   sow_pkg::sow_ctrl_type      ctrl;

   // Register port: writes complete in the access phase, no wait states.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = sow_pkg::reg_index_type'(paddr[sow_pkg::REG_SEL_BIT]);

   always_comb begin
      gain_in = gain_ff;
      mode_in = mode_ff;
      if (csr_write) begin
         unique case (reg_sel)
            sow_pkg::REG_GAIN: gain_in = pwdata[sow_pkg::GAIN_W-1:0];
            sow_pkg::REG_MODE: mode_in = sow_pkg::mode_type'(pwdata[1:0]);
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         sow_pkg::REG_GAIN: prdata = sow_pkg::CSR_DATA_W'(gain_ff);
         sow_pkg::REG_MODE: prdata = sow_pkg::CSR_DATA_W'(mode_ff);
      endcase
   end

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      ld[NS-1] = !v_ff[NS-1] || rsp_chan.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   always_comb begin
      v_in    = v_ff;
      last_in = last_ff;
      if (ld[0]) begin
         v_in[0]    = req_chan.valid;
         last_in[0] = req_chan.end_of_buffer;
      end
      for (int k = 1; k < NS; k++) begin
         if (ld[k]) begin
            v_in[k]    = v_ff[k-1];
            last_in[k] = last_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         gain_ff <= sow_pkg::GAIN_RESET;
         mode_ff <= sow_pkg::MODE_NATURAL;
      end else begin
         v_ff    <= v_in;
         gain_ff <= gain_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   assign ctrl.load = ld;
   assign ctrl.gain = gain_ff;
   assign ctrl.mode = mode_ff;

   // One datapath per channel, sharing the stage strobes.
   sow_channel #(
      .EXP_TABLE_ENTRIES  (EXP_TABLE_ENTRIES),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_left (
      .clock      (clock),
      .ctrl       (ctrl),
      .sample_in  (req_chan.left_in),
      .sample_out (rsp_chan.left_out)
   );

   sow_channel #(
      .EXP_TABLE_ENTRIES  (EXP_TABLE_ENTRIES),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_right (
      .clock      (clock),
      .ctrl       (ctrl),
      .sample_in  (req_chan.right_in),
      .sample_out (rsp_chan.right_out)
   );

   assign req_chan.ready    = ld[0];
   assign rsp_chan.valid    = v_ff[NS-1];
   assign rsp_chan.last_out = last_ff[NS-1];

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> v_ff == '0)
      else $error("pipeline not empty after reset");

   // Input back-pressure only when every stage holds an item.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> &v_ff)
      else $error("input stalled with a free stage");

   // An accepted item lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[0])
      else $error("accepted item lost at the first stage");

   // A first-stage item that cannot move keeps its mark.
   a_hold_first: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && !ld[1] |=> v_ff[0] && $stable(last_ff[0]))
      else $error("stalled first stage changed");

endmodule

`default_nettype wire

// ===== dv/sow_pair_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo overdrive waveshaper pair checker
// Watches the register port and both sample channels. It keeps its own copy
// of gain and mode, predicts the shaped pair for every accepted item and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module sow_pair_checker #(
   parameter int EXP_TABLE_ENTRIES  = 256,
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   sow_req_if                                 req_mon,
   sow_rsp_if                                 rsp_mon,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sow_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [sow_pkg::CSR_DATA_W-1:0]     pwdata,
   input  logic                               pready,
   output int                                 mismatch_count,
   output int                                 pending_pairs,
   output int                                 pairs_checked
);

   localparam longint unsigned CLIP_MAG     = 9830;
   localparam longint unsigned POS_LIMIT    = 32767;
   localparam longint unsigned NEG_LIMIT    = 32768;
   localparam longint unsigned ONE_Q32      = 64'd1 << 32;
   localparam int              TAYLOR_TERMS = 24;
   localparam int              SQUARINGS    = 4;

   typedef struct packed {
      logic [sow_pkg::SAMPLE_W-1:0] left;
      logic [sow_pkg::SAMPLE_W-1:0] right;
      logic                         last;
   } shaped_pair_type;

   shaped_pair_type            expected_pairs[$];
   int unsigned                knee_table[0:EXP_TABLE_ENTRIES];
   logic [sow_pkg::GAIN_W-1:0] shadow_gain;
   sow_pkg::mode_type          shadow_mode;
   int                         errors  = 0;
   int                         checked = 0;

   // One table entry: 1 - e^(-12 i / N) in Q0.16. The exponential is built
   // as a Taylor series of e^(-t/16) in Q32, squared four times.
   function automatic int unsigned knee_entry(int unsigned i);
      longint unsigned slope;
      longint unsigned term;
      longint unsigned e;
      longint          acc;
      slope = ((64'(i) * 3) << 32) / 64'(4 * EXP_TABLE_ENTRIES);
      term  = ONE_Q32;
      acc   = longint'(ONE_Q32);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = ((term * slope) >> 32) / 64'(k);
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      e = acc;
      for (int r = 0; r < SQUARINGS; r++) begin
         if (e < ONE_Q32) begin
            e = (e * e + (64'd1 << 31)) >> 32;
         end else begin
            e = ONE_Q32;
         end
      end
      e = (e + (64'd1 << 15)) >> 16;
      if (e > 64'd65536) begin
         e = 64'd65536;
      end
      e = 64'd65536 - e;
      return (e > 64'd65535) ? 32'd65535 : 32'(e);
   endfunction

   initial begin
      for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
         knee_table[i] = knee_entry(i);
      end
   end

   // Interpolated soft knee for a magnitude and a steepness factor.
   function automatic int unsigned soft_knee(longint unsigned mag, longint unsigned steep);
      longint unsigned pos;
      longint unsigned idx;
      longint unsigned lo;
      longint unsigned hi;
      pos = (mag * steep * 64'(EXP_TABLE_ENTRIES)) >> (1 + GAIN_FRACTION_BITS);
      idx = pos >> 16;
      if (idx >= 64'(EXP_TABLE_ENTRIES)) begin
         return knee_table[EXP_TABLE_ENTRIES];
      end
      lo = knee_table[idx];
      hi = knee_table[idx + 1];
      return 32'(lo + (((hi - lo) * (pos & 64'hFFFF)) >> 16));
   endfunction

   // Gain, then shape one channel sample in the given mode.
   function automatic logic [sow_pkg::SAMPLE_W-1:0] overdrive_sample(
      logic signed [sow_pkg::SAMPLE_W-1:0] s,
      logic [sow_pkg::GAIN_W-1:0]          g,
      sow_pkg::mode_type                   m);
      longint          prod;
      longint          shaped;
      longint unsigned mag;
      longint unsigned level;
      bit              neg;
      prod = longint'(s) * longint'({1'b0, g});
      neg  = (prod < 0);
      mag  = neg ? -prod : prod;
      case (m)
         sow_pkg::MODE_NATURAL: begin
            level = mag >> GAIN_FRACTION_BITS;
            if (neg) begin
               shaped = (level > NEG_LIMIT) ? -longint'(NEG_LIMIT) : -longint'(level);
            end else begin
               shaped = (level > POS_LIMIT) ? longint'(POS_LIMIT) : longint'(level);
            end
         end
         sow_pkg::MODE_CLIP: begin
            level = mag >> GAIN_FRACTION_BITS;
            if (level > CLIP_MAG) begin
               level = CLIP_MAG;
            end
            shaped = neg ? -longint'(level) : longint'(level);
         end
         sow_pkg::MODE_EXP: begin
            level  = soft_knee(mag, 1) >> 1;
            shaped = neg ? -longint'(level) : longint'(level);
         end
         default: begin
            // Asymmetric: the steeper, lower curve on the positive half only.
            if (neg) begin
               shaped = -longint'(soft_knee(mag, 1) >> 1);
            end else begin
               shaped = longint'((soft_knee(mag, 3) / 3) >> 1);
            end
         end
      endcase
      return shaped[sow_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic compare_field(string field, logic [sow_pkg::SAMPLE_W-1:0] want,
                                logic [sow_pkg::SAMPLE_W-1:0] seen);
      if (want !== seen) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                  $time, field, $signed(want), want, $signed(seen), seen);
      end
   endtask

   // Track register writes, queue predictions and check results.
   always @(posedge clock) begin : monitor
      shaped_pair_type want;
      shaped_pair_type seen;
      if (reset) begin
         expected_pairs.delete();
         shadow_gain <= sow_pkg::GAIN_RESET;
         shadow_mode <= sow_pkg::MODE_NATURAL;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (sow_pkg::reg_index_type'(paddr[sow_pkg::REG_SEL_BIT]))
               sow_pkg::REG_GAIN: shadow_gain <= pwdata[sow_pkg::GAIN_W-1:0];
               sow_pkg::REG_MODE: shadow_mode <= sow_pkg::mode_type'(pwdata[1:0]);
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            want.left  = overdrive_sample(req_mon.left_in, shadow_gain, shadow_mode);
            want.right = overdrive_sample(req_mon.right_in, shadow_gain, shadow_mode);
            want.last  = req_mon.end_of_buffer;
            expected_pairs.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.left  = rsp_mon.left_out;
            seen.right = rsp_mon.right_out;
            seen.last  = rsp_mon.last_out;
            if (expected_pairs.size() == 0) begin
               errors++;
               $display("%0t: unexpected item on the output, actual %h", $time, seen);
            end else begin
               want = expected_pairs.pop_front();
               compare_field("left_out", want.left, seen.left);
               compare_field("right_out", want.right, seen.right);
               compare_field("last_out", sow_pkg::SAMPLE_W'(want.last),
                             sow_pkg::SAMPLE_W'(seen.last));
               checked++;
            end
         end
      end
      mismatch_count <= errors;
      pending_pairs  <= expected_pairs.size();
      pairs_checked  <= checked;
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo overdrive waveshaper testbench
// Drives sample pairs in bursts through a series of gain and mode settings,
// stalls the output on changing patterns, and lets the pair checker predict
// and compare every shaped pair.
// ----------------------------------------------------------------------------

module tb;

   localparam int TABLE_ENTRIES = 256;
   localparam int FRACTION_BITS = 8;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_PAIRS   = 102;
   localparam int DRAIN_SLACK   = sow_pkg::NUM_STAGES + 4;
   localparam int HOLD_CYCLES   = 90;
   localparam int HOLD_AFTER    = 600;
   localparam int CYCLE_LIMIT   = 300000;

   logic                           clock;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [sow_pkg::CSR_ADDR_W-1:0] paddr;
   logic [sow_pkg::CSR_DATA_W-1:0] pwdata;
   logic [sow_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   int mismatch_count;
   int pending_pairs;
   int pairs_checked;
   int pairs_sent    = 0;
   int settings_used = 1;
   int burst_left    = 0;
   int cycle_count   = 0;

   sow_req_if req_bus ();
   sow_rsp_if rsp_bus ();

   stereo_overdrive_waveshaper #(
      .EXP_TABLE_ENTRIES  (TABLE_ENTRIES),
      .GAIN_FRACTION_BITS (FRACTION_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   sow_pair_checker #(
      .EXP_TABLE_ENTRIES  (TABLE_ENTRIES),
      .GAIN_FRACTION_BITS (FRACTION_BITS)
   ) pair_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .pending_pairs  (pending_pairs),
      .pairs_checked  (pairs_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit, in case the block stops answering.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("stereo_overdrive_waveshaper test failed");
      $finish;
   end

   // Output stall patterns, with one long hold-off once the run is under way.
   initial begin : output_stalls
      int style;
      int span;
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(10, 150);
         for (int n = 0; n < span; n++) begin
            @(posedge clock);
            if (hold_left > 0) begin
               hold_left--;
               rsp_bus.ready <= 1'b0;
            end else if (!hold_done && pairs_sent >= HOLD_AFTER) begin
               hold_done = 1'b1;
               hold_left = HOLD_CYCLES - 1;
               rsp_bus.ready <= 1'b0;
            end else begin
               case (style)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= ($urandom_range(0, 9) < 7);
                  2: rsp_bus.ready <= ($urandom_range(0, 9) < 3);
                  default: rsp_bus.ready <= (n % 3 == 0);
               endcase
            end
         end
      end
   end

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(sow_pkg::reg_index_type idx,
                            logic [sow_pkg::CSR_DATA_W-1:0] word);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= sow_pkg::CSR_ADDR_W'(idx) << sow_pkg::REG_SEL_BIT;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every predicted pair has come out, then let the pipe settle.
   task automatic wait_drained();
      do @(posedge clock); while (pending_pairs != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // New gain and mode while idle; unused upper register bits get junk.
   task automatic configure(logic [sow_pkg::GAIN_W-1:0] g, sow_pkg::mode_type m);
      logic [sow_pkg::CSR_DATA_W-1:0] gain_word;
      logic [sow_pkg::CSR_DATA_W-1:0] mode_word;
      gain_word         = $urandom;
      gain_word[sow_pkg::GAIN_W-1:0] = g;
      mode_word         = $urandom;
      mode_word[1:0]    = m;
      req_bus.valid <= 1'b0;
      wait_drained();
      csr_write(sow_pkg::REG_GAIN, gain_word);
      csr_write(sow_pkg::REG_MODE, mode_word);
      settings_used++;
   endtask

   // Offer one item; the sender may pause between bursts of random length.
   task automatic offer_pair(logic signed [sow_pkg::SAMPLE_W-1:0] left,
                             logic signed [sow_pkg::SAMPLE_W-1:0] right, logic eob);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid         <= 1'b0;
            req_bus.left_in       <= sow_pkg::SAMPLE_W'($urandom);
            req_bus.right_in      <= sow_pkg::SAMPLE_W'($urandom);
            req_bus.end_of_buffer <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.left_in       <= left;
      req_bus.right_in      <= right;
      req_bus.end_of_buffer <= eob;
      do @(posedge clock); while (!req_bus.ready);
      pairs_sent++;
   endtask

   // Mostly full-range samples, some small ones and some extremes.
   function automatic logic signed [sow_pkg::SAMPLE_W-1:0] pick_sample();
      int sel;
      logic signed [sow_pkg::SAMPLE_W-1:0] s;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 4))
            0: s = 16'sh8000;
            1: s = 16'sh7FFF;
            2: s = 16'sh0000;
            3: s = -16'sd1;
            default: s = 16'sd1;
         endcase
      end else if (sel <= 2) begin
         s = sow_pkg::SAMPLE_W'($urandom_range(0, 511));
         if ($urandom_range(0, 1) == 1) begin
            s = -s;
         end
      end else begin
         s = sow_pkg::SAMPLE_W'($urandom);
      end
      return s;
   endfunction

   initial begin : stimulus
      logic [sow_pkg::GAIN_W-1:0] g;
      sow_pkg::mode_type          m;
      reset   <= 1'b1;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.left_in       <= '0;
      req_bus.right_in      <= '0;
      req_bus.end_of_buffer <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: unity gain, natural.
      offer_pair(16'sh7FFF, 16'sh8000, 1'b1);
      offer_pair(16'sd0, -16'sd1, 1'b0);
      offer_pair(16'sd1, 16'sd12345, 1'b1);

      // Full gain in natural mode overflows and saturates.
      configure(16'hFFFF, sow_pkg::MODE_NATURAL);
      offer_pair(16'sh7FFF, 16'sh8000, 1'b0);
      offer_pair(16'sd1, -16'sd1, 1'b1);
      offer_pair(16'sd300, -16'sd300, 1'b0);

      // Hard clip right at and just past the clip level.
      configure(16'd512, sow_pkg::MODE_CLIP);
      offer_pair(16'sh7FFF, 16'sh8000, 1'b0);
      offer_pair(16'sd4915, -16'sd4916, 1'b1);
      offer_pair(16'sd4916, -16'sd4915, 1'b0);

      // Exponential curve, then driven beyond the end of the table.
      configure(16'd256, sow_pkg::MODE_EXP);
      offer_pair(16'sh7FFF, 16'sh8000, 1'b1);
      offer_pair(16'sd100, -16'sd100, 1'b0);
      offer_pair(16'sd0, 16'sd0, 1'b1);
      configure(16'hFFFF, sow_pkg::MODE_EXP);
      offer_pair(16'sh7FFF, 16'sh8000, 1'b0);
      offer_pair(16'sd2, -16'sd2, 1'b1);

      // Asymmetric curve, then zero gain.
      configure(16'd256, sow_pkg::MODE_ASYM);
      offer_pair(16'sh7FFF, 16'sh8000, 1'b0);
      offer_pair(16'sd5000, -16'sd5000, 1'b1);
      offer_pair(16'sd1, -16'sd1, 1'b0);
      configure(16'd0, sow_pkg::MODE_ASYM);
      offer_pair(16'sd12345, -16'sd12345, 1'b1);
      offer_pair(16'sh7FFF, 16'sh8000, 1'b0);

      // Random phases: every mode, alternating extreme and moderate gains.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         m = sow_pkg::mode_type'((p / 2) % 4);
         if (p % 2 == 1) begin
            case ($urandom_range(0, 3))
               0: g = 16'd0;
               1: g = 16'd1;
               2: g = 16'd256;
               default: g = 16'hFFFF;
            endcase
         end else if (p % 4 == 2) begin
            g = sow_pkg::GAIN_W'($urandom);
         end else begin
            g = sow_pkg::GAIN_W'($urandom_range(64, 2048));
         end
         configure(g, m);
         for (int n = 0; n < PHASE_PAIRS; n++) begin
            offer_pair(pick_sample(), pick_sample(), ($urandom_range(0, 3) == 0));
         end
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      $display("Checked %0d shaped pairs over %0d gain and mode settings, all four modes.",
               pairs_checked, settings_used);
      $display("Included a %0d-cycle output hold-off with the input still offered items.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_pairs == 0) begin
         $display("stereo_overdrive_waveshaper test passed");
      end else begin
         $display("stereo_overdrive_waveshaper test failed");
      end
      $finish;
   end

endmodule
